FILE: sv/fraction_accumulator_reduce_assert.svh
// assertion macros for the fraction accumulator
`ifndef FRACTION_ACCUMULATOR_REDUCE_ASSERT_SVH
`define FRACTION_ACCUMULATOR_REDUCE_ASSERT_SVH

// property must hold whenever reset is released
`define FAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the next clock
`define FAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/far_pkg.sv
`default_nettype none
package far_pkg;
  localparam int DATA_WIDTH = 32;
  localparam int IO_WIDTH = 32;
  localparam int CNT_WIDTH = $clog2(DATA_WIDTH + 1);
  localparam logic CFG_IDX_NUM = 1'b0;
  localparam logic CFG_IDX_DEN = 1'b1;
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_MUL = 1'b1;

  typedef struct packed {
    logic mode;
    logic [DATA_WIDTH-1:0] on;
    logic [DATA_WIDTH-1:0] od;
  } far_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_SUM, ST_GCD_START, ST_DIV_RUN, ST_GCD_NEXT,
    ST_QN_START, ST_QN_DONE, ST_QD_DONE, ST_EMIT
  } far_state_t;

  function automatic logic [IO_WIDTH-1:0] to_io(input logic [DATA_WIDTH-1:0] v);
    logic [63:0] e;
    e = 64'(signed'(v));
    return e[IO_WIDTH-1:0];
  endfunction

  function automatic logic [DATA_WIDTH-1:0] from_io(input logic [IO_WIDTH-1:0] v);
    logic [63:0] e;
    e = 64'(signed'(v));
    return e[DATA_WIDTH-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: sv/far_divider.sv
`default_nettype none
// restoring signed divider, one quotient bit per cycle, truncating
module far_divider import far_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output logic                       busy,
  output logic [DATA_WIDTH-1:0]      quotient,
  output logic [DATA_WIDTH-1:0]      remainder
);
  logic [CNT_WIDTH-1:0]  cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic [DATA_WIDTH-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [DATA_WIDTH:0]   rem_r, rem_nxt;
  logic                  qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic [DATA_WIDTH:0]   trial;

  always_comb begin
    cnt_nxt = cnt_r; busy_nxt = busy_r; q_nxt = q_r; d_nxt = d_r;
    rem_nxt = rem_r; qneg_nxt = qneg_r; rneg_nxt = rneg_r;
    trial = {rem_r[DATA_WIDTH-1:0], q_r[DATA_WIDTH-1]} - {1'b0, d_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = CNT_WIDTH'(DATA_WIDTH);
      q_nxt = dividend[DATA_WIDTH-1] ? -dividend : dividend;
      d_nxt = divisor[DATA_WIDTH-1] ? -divisor : divisor;
      rem_nxt = '0;
      qneg_nxt = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      rneg_nxt = dividend[DATA_WIDTH-1];
    end else if (busy_r) begin
      if (trial[DATA_WIDTH]) begin
        rem_nxt = {rem_r[DATA_WIDTH-1:0], q_r[DATA_WIDTH-1]};
        q_nxt = {q_r[DATA_WIDTH-2:0], 1'b0};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[DATA_WIDTH-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_WIDTH'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt;
    qneg_r <= qneg_nxt; rneg_r <= rneg_nxt;
  end

  assign busy = busy_r;
  assign quotient = qneg_r ? -q_r : q_r;
  assign remainder = rneg_r ? -rem_r[DATA_WIDTH-1:0] : rem_r[DATA_WIDTH-1:0];
endmodule
`default_nettype wire

FILE: sv/far_front.sv
`default_nettype none
// input side: takes words and holds a two-entry command queue
module far_front import far_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire logic                in_mode,
  input  wire logic [IO_WIDTH-1:0] in_operand_numerator,
  input  wire logic [IO_WIDTH-1:0] in_operand_denominator,
  output logic                     cmd_valid,
  output far_cmd_t                 cmd,
  input  wire logic                cmd_take
);
  far_cmd_t   q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push_ok, pop_ok;

  assign in_full = cnt_r == 2'd2;
  assign push_ok = in_push && !in_full;
  assign cmd_valid = cnt_r != 2'd0;
  assign pop_ok = cmd_take && cmd_valid;
  assign cmd = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (pop_ok) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    end
    if (push_ok) begin
      q_r[wp_r] <= '{mode: in_mode, on: from_io(in_operand_numerator),
                     od: from_io(in_operand_denominator)};
    end
  end
endmodule
`default_nettype wire

FILE: sv/far_back.sv
`default_nettype none
// execution side: update, gcd loop, two divisions, result register
module far_back import far_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic                cfg_hit,
  input  wire logic [IO_WIDTH-1:0] cfg_wdata,
  input  wire logic                cmd_valid,
  input  wire far_cmd_t            cmd,
  output logic                     cmd_take,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic [IO_WIDTH-1:0]      out_reduced_numerator,
  output logic [IO_WIDTH-1:0]      out_reduced_denominator,
  output logic                     out_zero_gcd_error
);
  far_state_t state_r, state_nxt;
  far_cmd_t   c_r;
  logic [DATA_WIDTH-1:0] num_r, den_r, p1_r, p2_r, p3_r, a_r, b_r, qn_r;
  logic [DATA_WIDTH-1:0] dv_a, dv_b, dv_q, dv_r;
  logic dv_start, dv_busy;
  logic ovalid_r;
  logic [IO_WIDTH-1:0] on_r, od_r;
  logic oerr_r;

  far_divider u_div (.clk, .rst_n, .start(dv_start), .dividend(dv_a), .divisor(dv_b),
                     .busy(dv_busy), .quotient(dv_q), .remainder(dv_r));

  always_comb begin
    state_nxt = state_r;
    cmd_take = 1'b0;
    dv_start = 1'b0;
    dv_a = a_r;
    dv_b = b_r;
    case (state_r)
      ST_IDLE: if (cmd_valid) begin
        cmd_take = 1'b1;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_SUM;
      ST_SUM: state_nxt = ST_GCD_START;
      ST_GCD_START: begin
        if (b_r == '0) state_nxt = ST_QN_START;
        else begin
          dv_start = 1'b1;
          state_nxt = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: if (!dv_busy) state_nxt = ST_GCD_NEXT;
      ST_GCD_NEXT: state_nxt = ST_GCD_START;
      ST_QN_START: begin
        if (a_r == '0) state_nxt = ST_EMIT;
        else begin
          // a holds the gcd here
          dv_a = num_r;
          dv_b = a_r;
          dv_start = 1'b1;
          state_nxt = ST_QN_DONE;
        end
      end
      ST_QN_DONE: if (!dv_busy) begin
        dv_a = den_r;
        dv_b = a_r;
        dv_start = 1'b1;
        state_nxt = ST_QD_DONE;
      end
      ST_QD_DONE: if (!dv_busy) state_nxt = ST_EMIT;
      ST_EMIT: if (!ovalid_r || out_pop) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovalid_r <= 1'b0;
      num_r <= '0;
      den_r <= DATA_WIDTH'(1);
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EMIT && (!ovalid_r || out_pop)) ovalid_r <= 1'b1;
      else if (out_pop && ovalid_r) ovalid_r <= 1'b0;
      if (cfg_we && cfg_hit) begin
        if (cfg_index == CFG_IDX_NUM) num_r <= from_io(cfg_wdata);
        else den_r <= from_io(cfg_wdata);
      end
      case (state_r)
        ST_SUM: begin
          if (c_r.mode == MODE_MUL) begin
            num_r <= p1_r; den_r <= p2_r;
            a_r <= p1_r; b_r <= p2_r;
          end else if (den_r == c_r.od) begin
            num_r <= num_r + c_r.on;
            a_r <= num_r + c_r.on; b_r <= den_r;
          end else begin
            num_r <= p3_r; den_r <= p2_r;
            a_r <= p3_r; b_r <= p2_r;
          end
        end
        default: ;
      endcase
    end
    if (cmd_take) c_r <= cmd;
    case (state_r)
      // add: p3 = num*od then plus den*on, p2 = den*on then den*od; mul: p1 = num*on
      ST_MUL1: begin
        p1_r <= num_r * c_r.on;
        p3_r <= num_r * c_r.od;
        p2_r <= den_r * c_r.on;
      end
      ST_MUL2: begin
        if (c_r.mode == MODE_ADD && den_r != c_r.od) p3_r <= p3_r + p2_r;
        p2_r <= den_r * c_r.od;
      end
      ST_GCD_NEXT: begin
        a_r <= b_r; b_r <= dv_r;
      end
      default: ;
    endcase
    if (state_r == ST_QN_DONE && !dv_busy) qn_r <= dv_q;
    if (state_r == ST_EMIT && (!ovalid_r || out_pop)) begin
      if (a_r == '0) begin
        on_r <= '0; od_r <= '0; oerr_r <= 1'b1;
      end else begin
        on_r <= to_io(qn_r); od_r <= to_io(dv_q); oerr_r <= 1'b0;
      end
    end
  end

  assign out_empty = !ovalid_r;
  assign out_reduced_numerator = on_r;
  assign out_reduced_denominator = od_r;
  assign out_zero_gcd_error = oerr_r;
endmodule
`default_nettype wire

FILE: sv/fraction_accumulator_reduce.sv
`default_nettype none
// running fraction accumulator: each word adds (mode 0) or multiplies (mode 1)
// an operand fraction into an unreduced 32-bit numerator/denominator pair and
// reports that pair divided by its euclid gcd (truncating, sign kept); both
// parts zero gives zeros with zero_gcd_error set. cfg index 0 and 1 load the
// running numerator and denominator. an item is taken and updated (two
// multiply steps and a sum), then runs one division per remainder step of
// the gcd loop, sees the loop end, runs the two quotient divisions and is
// emitted; when both parts are zero no division runs. the single
// one-bit-per-cycle divider is shared by every remainder and both final
// quotients. a two-word input queue lets the next word wait while one is in
// work, and one output register holds the result.
module fraction_accumulator_reduce import far_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire logic                in_mode,
  input  wire logic [IO_WIDTH-1:0] in_operand_numerator,
  input  wire logic [IO_WIDTH-1:0] in_operand_denominator,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic [IO_WIDTH-1:0]      out_reduced_numerator,
  output logic [IO_WIDTH-1:0]      out_reduced_denominator,
  output logic                     out_zero_gcd_error,
  input  wire logic                cfg_we,
  input  wire logic [IO_WIDTH-1:0] cfg_index,
  input  wire logic [IO_WIDTH-1:0] cfg_wdata
);
  // command words between the front and back parts
  logic     cmd_valid, cmd_take;
  far_cmd_t cmd;
  // register index must select one of the two registers, else ignored
  logic     cfg_hit;
  assign cfg_hit = cfg_index[IO_WIDTH-1:1] == '0;

  far_front u_front (.clk, .rst_n, .in_push, .in_full, .in_mode,
                     .in_operand_numerator, .in_operand_denominator,
                     .cmd_valid, .cmd, .cmd_take);

  far_back u_back (.clk, .rst_n, .cfg_we, .cfg_index(cfg_index[0]), .cfg_hit,
                   .cfg_wdata, .cmd_valid, .cmd, .cmd_take, .out_empty, .out_pop,
                   .out_reduced_numerator, .out_reduced_denominator,
                   .out_zero_gcd_error);

`include "fraction_accumulator_reduce_assert.svh"
  // error results always carry zero fractions
  `FAR_ASSERT(a_err_zero, !(!out_empty && out_zero_gcd_error) || (out_reduced_numerator == '0 && out_reduced_denominator == '0), "error word with nonzero fraction")
  // a waiting result holds until popped
  `FAR_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_reduced_numerator), "result changed while waiting")
  // the queue stays full until a word is taken
  `FAR_ASSERT_NEXT(a_full_hold, in_full && !cmd_take, in_full, "queue lost fullness without a take")
endmodule
`default_nettype wire
